/* hw/rtl/ssi_pkg.sv */
// Package for the sorted set insertion block: key type, result status codes
// and the command word that the top level broadcasts to the row of cells.
// No dependencies.
`default_nettype none

package ssi_pkg;

  // Keys are signed 32-bit values, ordered as two's complement numbers.
  localparam int unsigned KeyWidth = 32;
  typedef logic signed [KeyWidth-1:0] key_t;

  // Width of the capacity register and of the position and count results.
  localparam int unsigned FieldWidth = 5;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Command broadcast to every cell: compare against a key, or insert it.
  typedef struct packed {
    logic cmp;
    logic ins;
    key_t key;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_set_insert_top.sv */
// Top level of the sorted set insertion block: a row of DEPTH cells holding
// an ascending table of distinct signed keys, plus count and result logic.
// Depends on ssi_pkg and ssi_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, new_key_i) carries one key per word.
//   Output channel (out_valid_o/out_ready_i) returns one result word per key:
//   status_o (inserted, duplicate, full), position_o and entries_used_o.
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_capacity_i) writes the
//   capacity register; it is always ready. It must be written only while idle;
//   the block itself does not enforce this. For each key, every cell compares
//   its entry with the key when the key is accepted; once the output register
//   is free, the row shifts and the result is registered. A new key is
//   accepted only after the previous key's update.
//   If the receiver stalls, the result stays in the output register; one more
//   key may be accepted and compared, and its update waits for the output
//   register to free up.
//   Reset clears the count, all cell valid bits and the output valid, and
//   sets capacity to 16. No clearing pass is needed.
`default_nettype none

module sorted_set_insert_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ssi_pkg::FieldWidth-1:0]     cfg_capacity_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ssi_pkg::key_t                      new_key_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [ssi_pkg::FieldWidth-1:0]     position_o,
  output logic [ssi_pkg::FieldWidth-1:0]     entries_used_o
);
  import ssi_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > FieldWidth) ? CW : FieldWidth;

  logic [FieldWidth-1:0] capacity_q;
  logic [CW-1:0]         count_q, count_d;
  logic                  busy_q;
  key_t                  key_q;

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [FieldWidth-1:0] position_q;
  logic [FieldWidth-1:0] used_q;

  cell_cmd_t             cmd;
  logic [DEPTH-1:0]      lt_vec, eq_vec, valid_vec, left_lt_vec, left_valid_vec;
  key_t                  key_arr [DEPTH];
  key_t                  left_key_arr [DEPTH];

  logic [LW-1:0]         cap_ext, lim;
  logic                  full, dup, out_free, finish, do_ins;
  logic [DEPTH-1:0]      boundary;
  logic [CW-1:0]         pos_enc, pos_res;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= FieldWidth'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_capacity_i;
    end
  end

  // Effective limit: zero counts as one, anything above DEPTH saturates.
  always_comb begin
    cap_ext = LW'(capacity_q);
    if (capacity_q == '0) begin
      lim = LW'(1);
    end else if (cap_ext > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end else begin
      lim = cap_ext;
    end
  end

  // Handshake control: compare on accept, update when the output is free.
  assign in_ready_o = !busy_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign finish     = busy_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      busy_q <= 1'b1;
    end else if (finish) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= new_key_i;
    end
  end

  // Command broadcast to the row.
  always_comb begin
    cmd.cmp = in_valid_i && in_ready_o;
    cmd.ins = do_ins;
    cmd.key = busy_q ? key_q : new_key_i;
  end

  // Neighbor links; the left edge acts as a smaller, valid entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_link
    if (i == 0) begin : g_first
      assign left_lt_vec[i]    = 1'b1;
      assign left_valid_vec[i] = 1'b1;
      assign left_key_arr[i]   = key_q;
    end else begin : g_rest
      assign left_lt_vec[i]    = lt_vec[i-1];
      assign left_valid_vec[i] = valid_vec[i-1];
      assign left_key_arr[i]   = key_arr[i-1];
    end
  end

  // The row of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ssi_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_lt_i   (left_lt_vec[i]),
      .left_valid_i(left_valid_vec[i]),
      .left_key_i  (left_key_arr[i]),
      .lt_o        (lt_vec[i]),
      .eq_o        (eq_vec[i]),
      .valid_o     (valid_vec[i]),
      .key_o       (key_arr[i])
    );
  end

  // The smaller-than flags form a prefix; its end is the insertion point,
  // which is also where an equal key sits.
  assign boundary = left_lt_vec & ~lt_vec;

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (boundary[i]) begin
        pos_enc = pos_enc | CW'(i);
      end
    end
  end

  // Decision for the pending key.
  assign full   = (count_q != '0) && (LW'(count_q) >= lim);
  assign dup    = |eq_vec;
  assign do_ins = finish && !full && !dup;

  always_comb begin
    if (full) begin
      status_d = ST_FULL;
      pos_res  = '0;
    end else if (dup) begin
      status_d = ST_DUPLICATE;
      pos_res  = pos_enc;
    end else begin
      status_d = ST_INSERTED;
      pos_res  = pos_enc;
    end
  end

  assign count_d = do_ins ? count_q + CW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q   <= status_d;
      position_q <= FieldWidth'(pos_res);
      used_q     <= FieldWidth'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign position_o     = position_q;
  assign entries_used_o = used_q;

  // Distinct keys: at most one cell can match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  // Smaller-than flags must form a prefix of the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((lt_vec & ~left_lt_vec) == '0))
    else $error("compare flags are not a prefix");

  // Valid bits are a prefix whose length is the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((valid_vec & ~left_valid_vec) == '0) &&
     ($countones(valid_vec) == int'(count_q))))
    else $error("valid bits disagree with the count");

  // The count only grows by an insertion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(do_ins))
    else $error("count changed without an insertion");

endmodule

`default_nettype wire

/* hw/rtl/ssi_cell.sv */
// One cell of the sorted row: holds one key and its valid bit, compares
// against a broadcast key and shifts in its left neighbor's word on insert.
// Depends on ssi_pkg.
`default_nettype none

module ssi_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssi_pkg::cell_cmd_t cmd_i,
  input  logic              left_lt_i,
  input  logic              left_valid_i,
  input  ssi_pkg::key_t     left_key_i,
  output logic              lt_o,
  output logic              eq_o,
  output logic              valid_o,
  output ssi_pkg::key_t     key_o
);
  import ssi_pkg::*;

  key_t key_q;
  logic valid_q;
  logic lt_q;
  logic eq_q;

  // Compare flags, captured when a word is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      lt_q <= valid_q && (key_q < cmd_i.key);
      eq_q <= valid_q && (key_q == cmd_i.key);
    end
  end

  // Valid bit: cells at or above the insertion point take the left valid bit;
  // the cell at the insertion point becomes valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ins && !lt_q) begin
      valid_q <= left_lt_i | left_valid_i;
    end
  end

  // Key storage: the insertion point takes the new key, cells above it
  // take their left neighbor's key.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && !lt_q) begin
      key_q <= left_lt_i ? cmd_i.key : left_key_i;
    end
  end

  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

`default_nettype wire
